### hw/rtl/ptba_pkg.sv
// ============================================================================
// ptba_pkg
// Shared constants and helpers for the pose to body acceleration core.
// ============================================================================
`default_nettype none

package ptba_pkg;

    localparam int unsigned GRAVITY_W = 31;
    localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 31'd642908;
    localparam logic signed [20:0]   USEC_PER_SEC  = 21'sd1000000;
    localparam logic signed [35:0]   ONE_Q30       = 36'sd1073741824;
    localparam logic signed [69:0]   ROUND_Q30     = 70'sd536870912;
    localparam logic [31:0]          INT32_MAX     = 32'h7fff_ffff;
    localparam logic [31:0]          INT32_MIN     = 32'h8000_0000;

    // clamp a 40-bit signed value to 32 bits
    function automatic logic [31:0] sat40(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = INT32_MAX;
        end else if (v < -40'sd2147483648) begin
            r = INT32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pose_to_body_acceleration_core.sv
// ============================================================================
// pose_to_body_acceleration_core
// Body-frame acceleration from pose samples by finite differences, rotated
// into the body frame by the conjugate of the sample quaternion.
// ============================================================================
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | to core   | i_in_valid / o_in_stall   | stamp, pos xyz, rot xyzw
//  out     | from core | o_out_valid / i_out_stall | stamp, acc xyz, orient xyzw
//  cfg     | to core   | i_cfg_we                  | gravity (UQ15.16)
//
// A request that primes, restarts priming or is stale is absorbed without leaving idle.
// A request that yields velocity runs 3 rounding divisions, a full result 6;
// each division steps through multiply, prepare, 32 quotient bits (skipped on
// overflow) and finish. A full result adds quaternion products and a rotation;
// the pace is set by the single shared multiplier and the 1-bit divider.
// o_in_stall is high while a request is in work; the finished result sits in the
// output register, and the core waits in its last state if that is still full.
// Reset is synchronous, active low; it restores gravity and clears all history.
`default_nettype none

module pose_to_body_acceleration_core
    import ptba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [GRAVITY_W-1:0] i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [31:0]          i_stamp_us,
    input  wire logic signed [31:0]   i_pos_x,
    input  wire logic signed [31:0]   i_pos_y,
    input  wire logic signed [31:0]   i_pos_z,
    input  wire logic signed [15:0]   i_rot_x,
    input  wire logic signed [15:0]   i_rot_y,
    input  wire logic signed [15:0]   i_rot_z,
    input  wire logic signed [15:0]   i_rot_w,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [31:0]               o_out_stamp_us,
    output logic signed [31:0]        o_acc_x,
    output logic signed [31:0]        o_acc_y,
    output logic signed [31:0]        o_acc_z,
    output logic signed [15:0]        o_orient_x,
    output logic signed [15:0]        o_orient_y,
    output logic signed [15:0]        o_orient_z,
    output logic signed [15:0]        o_orient_w
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;  // |diff| * 1e6
    localparam logic [3:0] S_PREP = 4'd2;  // add d/2, overflow check
    localparam logic [3:0] S_DIV  = 4'd3;  // one quotient bit per cycle
    localparam logic [3:0] S_FIN  = 4'd4;  // sign, saturate, store
    localparam logic [3:0] S_QMUL = 4'd5;  // quaternion products
    localparam logic [3:0] S_QWR  = 4'd6;
    localparam logic [3:0] S_RMUL = 4'd7;  // matrix entry * vector half
    localparam logic [3:0] S_RACC = 4'd8;
    localparam logic [3:0] S_RROW = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // product slots
    localparam logic [3:0] QP_XX = 4'd0;
    localparam logic [3:0] QP_YY = 4'd1;
    localparam logic [3:0] QP_ZZ = 4'd2;
    localparam logic [3:0] QP_XY = 4'd3;
    localparam logic [3:0] QP_XZ = 4'd4;
    localparam logic [3:0] QP_YZ = 4'd5;
    localparam logic [3:0] QP_XW = 4'd6;
    localparam logic [3:0] QP_YW = 4'd7;
    localparam logic [3:0] QP_ZW = 4'd8;

    logic [3:0]            r_state;
    logic [GRAVITY_W-1:0]  r_gravity;
    logic [1:0]            r_fill;
    logic [31:0]           r_last_stamp;
    logic signed [31:0]    r_last_pos [3];
    logic signed [31:0]    r_last_vel [3];

    // request under work
    logic [31:0]           r_stamp;
    logic signed [31:0]    r_pos [3];
    logic signed [15:0]    r_q [4];   // x y z w
    logic [30:0]           r_d;

    logic                  r_phase;   // 0 velocity, 1 acceleration
    logic [1:0]            r_k;
    logic                  r_neg;
    logic signed [56:0]    r_prod;
    logic [30:0]           r_rem;
    logic [31:0]           r_qsh;
    logic                  r_ovf;
    logic [4:0]            r_cnt;
    logic signed [31:0]    r_vel [3];
    logic signed [31:0]    r_res [3];
    logic [3:0]            r_qi;
    logic signed [31:0]    r_qp [9];
    logic [1:0]            r_row;
    logic [1:0]            r_col;
    logic                  r_half;
    logic signed [69:0]    r_sum;
    logic signed [31:0]    r_body [3];

    // output register
    logic                  r_out_valid;
    logic [31:0]           r_o_stamp;
    logic signed [31:0]    r_o_acc [3];
    logic signed [15:0]    r_o_q [4];

    logic [31:0]           n_d;
    logic                  n_newer;
    logic                  n_accept;
    logic signed [32:0]    n_diff;
    logic [32:0]           n_mag;
    logic signed [35:0]    n_ma;
    logic signed [20:0]    n_mb;
    logic signed [56:0]    n_prod;
    logic [53:0]           n_num;
    logic                  n_ovf;
    logic [31:0]           n_rem2;
    logic                  n_ge;
    logic [31:0]           n_q;
    logic [31:0]           n_fin;
    logic [31:0]           n_grav;
    logic signed [35:0]    n_entry;
    logic signed [15:0]    n_qa;
    logic signed [15:0]    n_qb;
    logic signed [31:0]    n_v;
    logic signed [69:0]    n_term;
    logic                  n_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign n_accept   = i_in_valid && (r_state == S_IDLE);
    assign n_d        = i_stamp_us - r_last_stamp;
    assign n_newer    = (n_d != 32'd0) && !n_d[31];
    assign n_out_free = !r_out_valid || !i_out_stall;

    // difference feeding the divider
    always_comb begin
        if (r_phase) begin
            n_diff = 33'(r_vel[r_k]) - 33'(r_last_vel[r_k]);
        end else begin
            n_diff = 33'(r_pos[r_k]) - 33'(r_last_pos[r_k]);
        end
        n_mag = n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
    end

    // quaternion product operands
    always_comb begin
        unique case (r_qi)
            QP_XX:   begin n_qa = r_q[0]; n_qb = r_q[0]; end
            QP_YY:   begin n_qa = r_q[1]; n_qb = r_q[1]; end
            QP_ZZ:   begin n_qa = r_q[2]; n_qb = r_q[2]; end
            QP_XY:   begin n_qa = r_q[0]; n_qb = r_q[1]; end
            QP_XZ:   begin n_qa = r_q[0]; n_qb = r_q[2]; end
            QP_YZ:   begin n_qa = r_q[1]; n_qb = r_q[2]; end
            QP_XW:   begin n_qa = r_q[0]; n_qb = r_q[3]; end
            QP_YW:   begin n_qa = r_q[1]; n_qb = r_q[3]; end
            QP_ZW:   begin n_qa = r_q[2]; n_qb = r_q[3]; end
            default: begin n_qa = '0;     n_qb = '0;     end
        endcase
    end

    // transposed rotation matrix entry, Q2.30
    always_comb begin
        unique case ({r_row, r_col})
            4'h0:    n_entry = ONE_Q30 - 36'((36'(r_qp[1]) + 36'(r_qp[2])) <<< 1);
            4'h1:    n_entry = 36'((36'(r_qp[3]) + 36'(r_qp[8])) <<< 1);
            4'h2:    n_entry = 36'((36'(r_qp[4]) - 36'(r_qp[7])) <<< 1);
            4'h4:    n_entry = 36'((36'(r_qp[3]) - 36'(r_qp[8])) <<< 1);
            4'h5:    n_entry = ONE_Q30 - 36'((36'(r_qp[0]) + 36'(r_qp[2])) <<< 1);
            4'h6:    n_entry = 36'((36'(r_qp[5]) + 36'(r_qp[6])) <<< 1);
            4'h8:    n_entry = 36'((36'(r_qp[4]) + 36'(r_qp[7])) <<< 1);
            4'h9:    n_entry = 36'((36'(r_qp[5]) - 36'(r_qp[6])) <<< 1);
            4'hA:    n_entry = ONE_Q30 - 36'((36'(r_qp[0]) + 36'(r_qp[1])) <<< 1);
            default: n_entry = '0;
        endcase
    end

    // shared multiplier
    always_comb begin
        n_v = r_res[r_col];
        unique case (r_state)
            S_MUL: begin
                n_ma = 36'($signed({3'b000, n_mag}));
                n_mb = USEC_PER_SEC;
            end
            S_QMUL: begin
                n_ma = 36'(n_qa);
                n_mb = 21'(n_qb);
            end
            S_RMUL: begin
                // upper half is signed, lower half is a plain fraction
                n_ma = n_entry;
                n_mb = r_half ? 21'($signed(n_v[31:16]))
                              : $signed({5'b00000, n_v[15:0]});
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_prod = 57'(n_ma) * 57'(n_mb);
    end

    // divider datapath
    always_comb begin
        n_num  = {1'b0, r_prod[52:0]} + {23'd0, r_d[30:1]};
        n_ovf  = ({9'd0, n_num[53:32]} >= r_d);
        n_rem2 = {r_rem, r_qsh[31]};
        n_ge   = (n_rem2 >= {1'b0, r_d});
        n_q    = r_qsh;
        if (r_neg) begin
            n_fin = (r_ovf || (n_q > INT32_MIN)) ? INT32_MIN : 32'(-n_q);
        end else begin
            n_fin = (r_ovf || n_q[31]) ? INT32_MAX : n_q;
        end
        n_grav = sat40(40'($signed(n_fin)) + 40'($signed({1'b0, r_gravity})));
        n_term = r_half ? 70'(r_prod) <<< 16 : 70'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gravity    <= GRAVITY_RESET;
            r_fill       <= 2'd0;
            r_last_stamp <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_last_pos[i] <= '0;
                r_last_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_gravity <= i_cfg_wdata;
            end
            // load a finished result, or free the register once taken
            if (r_state == S_OUT && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (r_fill == 2'd0 || (r_fill == 2'd1 && !n_newer)) begin
                            // start or restart priming
                            r_last_stamp  <= i_stamp_us;
                            r_last_pos[0] <= i_pos_x;
                            r_last_pos[1] <= i_pos_y;
                            r_last_pos[2] <= i_pos_z;
                            r_fill        <= 2'd1;
                        end else if (n_newer) begin
                            r_stamp  <= i_stamp_us;
                            r_pos[0] <= i_pos_x;
                            r_pos[1] <= i_pos_y;
                            r_pos[2] <= i_pos_z;
                            r_q[0]   <= i_rot_x;
                            r_q[1]   <= i_rot_y;
                            r_q[2]   <= i_rot_z;
                            r_q[3]   <= i_rot_w;
                            r_d      <= n_d[30:0];
                            r_phase  <= 1'b0;
                            r_k      <= 2'd0;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_neg   <= n_diff[32];
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_ovf   <= n_ovf;
                    r_rem   <= {9'd0, n_num[53:32]};
                    r_qsh   <= n_num[31:0];
                    r_cnt   <= 5'd0;
                    r_state <= n_ovf ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_ge ? 31'(n_rem2 - {1'b0, r_d}) : n_rem2[30:0];
                    r_qsh <= {r_qsh[30:0], n_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_phase) begin
                        r_res[r_k] <= (r_k == 2'd2) ? n_grav : n_fin;
                    end else begin
                        r_vel[r_k] <= n_fin;
                    end
                    if (r_k != 2'd2) begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_MUL;
                    end else if (r_phase) begin
                        r_qi    <= QP_XX;
                        r_state <= S_QMUL;
                    end else if (r_fill == 2'd1) begin
                        // second sample completes priming
                        r_last_stamp  <= r_stamp;
                        r_last_pos    <= r_pos;
                        r_last_vel[0] <= r_vel[0];
                        r_last_vel[1] <= r_vel[1];
                        r_last_vel[2] <= n_fin;
                        r_fill        <= 2'd2;
                        r_state       <= S_IDLE;
                    end else begin
                        r_phase <= 1'b1;
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_QMUL: begin
                    r_state <= S_QWR;
                end
                S_QWR: begin
                    r_qp[r_qi] <= r_prod[31:0];
                    if (r_qi == QP_ZW) begin
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_half  <= 1'b0;
                        r_sum   <= ROUND_Q30;
                        r_state <= S_RMUL;
                    end else begin
                        r_qi    <= r_qi + 4'd1;
                        r_state <= S_QMUL;
                    end
                end
                S_RMUL: begin
                    r_state <= S_RACC;
                end
                S_RACC: begin
                    r_sum  <= r_sum + n_term;
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_state <= S_RMUL;
                    end else if (r_col != 2'd2) begin
                        r_col   <= r_col + 2'd1;
                        r_state <= S_RMUL;
                    end else begin
                        r_state <= S_RROW;
                    end
                end
                S_RROW: begin
                    r_body[r_row] <= sat40(r_sum[69:30]);
                    r_sum         <= ROUND_Q30;
                    r_col         <= 2'd0;
                    if (r_row != 2'd2) begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_RMUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_o_stamp    <= r_stamp;
                        r_o_acc      <= r_body;
                        r_o_q        <= r_q;
                        r_last_stamp <= r_stamp;
                        r_last_pos   <= r_pos;
                        r_last_vel   <= r_vel;
                        r_fill       <= 2'd2;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_stamp_us = r_o_stamp;
    assign o_acc_x        = r_o_acc[0];
    assign o_acc_y        = r_o_acc[1];
    assign o_acc_z        = r_o_acc[2];
    assign o_orient_x     = r_o_q[0];
    assign o_orient_y     = r_o_q[1];
    assign o_orient_z     = r_o_q[2];
    assign o_orient_w     = r_o_q[3];

endmodule

`default_nettype wire

### hw/rtl/ptba_chk.sv
// ============================================================================
// ptba_chk
// Port-level checks for the pose to body acceleration core.
// ============================================================================
`default_nettype none

module ptba_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_out_stamp_us,
    input wire logic [31:0] o_acc_x
);

    // results only appear out of work in progress
    a_rise_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without request in work");

    // reset leaves the core idle and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not idle after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_stamp_us) && $stable(o_acc_x))
        else $error("result changed while stalled");

endmodule

bind pose_to_body_acceleration_core ptba_chk u_ptba_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_stamp_us (o_out_stamp_us),
    .o_acc_x        (o_acc_x)
);

`default_nettype wire

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for pose_to_body_acceleration_core: pose requests go in,
// a built-in finite-difference predictor works out each acceleration result,
// and every accepted result is compared field by field with the oldest prediction.
// ============================================================================
`default_nettype none

module tb_top;
    import ptba_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;  // cycles without any accepted request or result
    localparam int DRAIN_CYCLES   = 400;    // > one full computation
    localparam int HOLD_CYCLES    = 1500;   // long output hold-off

    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qx, qy, qz, qw;
    } pose_t;

    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [31:0] ax, ay, az;
        logic signed [15:0] qx, qy, qz, qw;
    } accel_t;

    // ------------------------------------------------------------------------
    // clock, DUT ports
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [GRAVITY_W-1:0] i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_stamp_us = '0;
    logic signed [31:0]   i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [15:0]   i_rot_x = '0, i_rot_y = '0, i_rot_z = '0, i_rot_w = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [31:0]          o_out_stamp_us;
    logic signed [31:0]   o_acc_x, o_acc_y, o_acc_z;
    logic signed [15:0]   o_orient_x, o_orient_y, o_orient_z, o_orient_w;

    pose_to_body_acceleration_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_stamp_us(i_stamp_us), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_rot_x(i_rot_x), .i_rot_y(i_rot_y),
        .i_rot_z(i_rot_z), .i_rot_w(i_rot_w),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_stamp_us(o_out_stamp_us), .o_acc_x(o_acc_x), .o_acc_y(o_acc_y),
        .o_acc_z(o_acc_z), .o_orient_x(o_orient_x), .o_orient_y(o_orient_y),
        .o_orient_z(o_orient_z), .o_orient_w(o_orient_w)
    );

    // ------------------------------------------------------------------------
    // predictor state: mirrors the core's history and gravity register
    // ------------------------------------------------------------------------
    logic [GRAVITY_W-1:0] gravity_q;
    logic [1:0]           held_count;
    logic [31:0]          prev_stamp;
    logic signed [31:0]   prev_pos [3];
    logic signed [31:0]   prev_vel [3];

    accel_t accel_pending [$];

    int  errors = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    bit  idle_on = 1'b1;       // random gaps/stalls on both sides
    bit  hold_req = 1'b0;      // ask the receiver for a long hold-off
    int  hold_cnt = 0;
    int  quiet_cycles = 0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // (n * 1e6) / d, rounded half away from zero
    function automatic logic signed [31:0] rate_of_change(longint n, logic [31:0] d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        mag = mag * 64'd1000000;
        q = (mag + {33'd0, d[31:1]}) / {32'd0, d};
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return clamp32((n < 0) ? -longint'(q) : longint'(q));
    endfunction

    // one row of R^T * a; matrix entries Q2.30, round half up
    function automatic logic signed [31:0] body_row(longint m0, longint m1, longint m2,
                                                    logic signed [31:0] a0,
                                                    logic signed [31:0] a1,
                                                    logic signed [31:0] a2);
        longint m [3];
        longint a [3];
        longint hi, lo, vh, vl;
        m[0] = m0; m[1] = m1; m[2] = m2;
        a[0] = a0; a[1] = a1; a[2] = a2;
        hi = 0;
        lo = 64'sd1 << 29;
        for (int i = 0; i < 3; i++) begin
            vh = a[i] >>> 16;
            vl = a[i] - vh * 65536;
            hi += m[i] * vh;
            lo += m[i] * vl;
        end
        return clamp32((hi + (lo >>> 16)) >>> 14);
    endfunction

    // advance the history by one accepted pose; returns 1 when a result is due
    function automatic bit predict_accel(pose_t p, output accel_t r);
        logic [31:0]        dt;
        bit                 newer;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] acc [3];
        longint             x, y, z, w;
        dt = p.stamp - prev_stamp;
        newer = (dt != 0) && !dt[31];
        pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
        r = '0;
        // empty, or a failed priming pair: the new pose replaces the held one
        if (held_count == 0 || (held_count == 1 && !newer)) begin
            prev_stamp = p.stamp;
            for (int i = 0; i < 3; i++) prev_pos[i] = pos[i];
            held_count = 1;
            return 1'b0;
        end
        if (!newer) return 1'b0;   // stale pose when primed
        for (int i = 0; i < 3; i++)
            vel[i] = rate_of_change(longint'(pos[i]) - longint'(prev_pos[i]), dt);
        if (held_count == 1) begin
            prev_stamp = p.stamp;
            for (int i = 0; i < 3; i++) begin
                prev_pos[i] = pos[i];
                prev_vel[i] = vel[i];
            end
            held_count = 2;
            return 1'b0;
        end
        for (int i = 0; i < 3; i++)
            acc[i] = rate_of_change(longint'(vel[i]) - longint'(prev_vel[i]), dt);
        acc[2] = clamp32(longint'(acc[2]) + longint'({33'd0, gravity_q}));
        x = p.qx; y = p.qy; z = p.qz; w = p.qw;
        r.stamp = p.stamp;
        r.ax = body_row((64'sd1 << 30) - 2 * (y * y + z * z), 2 * (x * y + z * w),
                        2 * (x * z - y * w), acc[0], acc[1], acc[2]);
        r.ay = body_row(2 * (x * y - z * w), (64'sd1 << 30) - 2 * (x * x + z * z),
                        2 * (y * z + x * w), acc[0], acc[1], acc[2]);
        r.az = body_row(2 * (x * z + y * w), 2 * (y * z - x * w),
                        (64'sd1 << 30) - 2 * (x * x + y * y), acc[0], acc[1], acc[2]);
        r.qx = p.qx; r.qy = p.qy; r.qz = p.qz; r.qw = p.qw;
        prev_stamp = p.stamp;
        for (int i = 0; i < 3; i++) begin
            prev_pos[i] = pos[i];
            prev_vel[i] = vel[i];
        end
        held_count = 2;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // input side: one request per call, called at a rising edge
    // ------------------------------------------------------------------------
    task automatic send_pose(pose_t p);
        accel_t r;
        if (idle_on && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_stamp_us <= p.stamp;
        i_pos_x <= p.px; i_pos_y <= p.py; i_pos_z <= p.pz;
        i_rot_x <= p.qx; i_rot_y <= p.qy; i_rot_z <= p.qz; i_rot_w <= p.qw;
        do @(posedge i_clk); while (o_in_stall);
        // accepted at this edge; valid stays up for a back-to-back request
        if (predict_accel(p, r)) accel_pending.push_back(r);
        requests_sent++;
    endtask

    task automatic drain_core();
        i_in_valid <= 1'b0;
        wait (accel_pending.size() == 0);
        // stale or priming requests leave no result; let any work finish
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gravity(logic [GRAVITY_W-1:0] g);
        drain_core();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gravity_q = g;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // output side: random stalls, long hold-off on request, result checking
    // ------------------------------------------------------------------------
    task automatic check_accel(accel_t exp_r);
        logic [31:0] e [8];
        logic [31:0] a [8];
        string       nm [8];
        nm = '{"stamp", "acc_x", "acc_y", "acc_z", "orient_x", "orient_y",
               "orient_z", "orient_w"};
        e = '{exp_r.stamp, exp_r.ax, exp_r.ay, exp_r.az, {16'd0, exp_r.qx},
              {16'd0, exp_r.qy}, {16'd0, exp_r.qz}, {16'd0, exp_r.qw}};
        a = '{o_out_stamp_us, o_acc_x, o_acc_y, o_acc_z, {16'd0, o_orient_x},
              {16'd0, o_orient_y}, {16'd0, o_orient_z}, {16'd0, o_orient_w}};
        for (int i = 0; i < 8; i++)
            if (e[i] !== a[i]) begin
                $display("%0t mismatch %s: expected %h actual %h", $time, nm[i], e[i], a[i]);
                errors++;
            end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (accel_pending.size() == 0) begin
                $display("%0t unexpected result: expected none actual stamp %h",
                         $time, o_out_stamp_us);
                errors++;
            end else begin
                check_accel(accel_pending.pop_front());
            end
        end
        if (hold_req && hold_cnt == 0) hold_cnt = HOLD_CYCLES;
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_req = 1'b0;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 33);
        end
    end

    // watchdog: cycles in which neither side accepts anything
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    logic [31:0] gen_stamp = 0;
    logic signed [31:0] gen_pos [3] = '{0, 0, 0};
    logic signed [31:0] gen_vel [3] = '{0, 0, 0};

    function automatic logic signed [15:0] rand_rot();
        return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16000) - 8000);
    endfunction

    // next pose of a smooth trajectory with random content
    function automatic pose_t next_pose();
        pose_t p;
        int    k;
        k = $urandom_range(99);
        if (k < 3)       gen_stamp += 32'd1;                       // tiny step
        else if (k < 5)  gen_stamp += 32'h7fffffff;                // longest newer step
        else if (k < 9)  gen_stamp += 32'h80000000 + $urandom;     // random step, may be stale or equal
        else             gen_stamp += $urandom_range(1000, 60000);
        if (k >= 5 && k < 7) gen_stamp = gen_stamp - (gen_stamp - gen_stamp); // keep
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(99) < 4) gen_pos[i] = $urandom;     // jump anywhere
            else begin
                gen_vel[i] += $urandom_range(0, 4096) - 2048;
                gen_pos[i] += gen_vel[i];
            end
        end
        p.stamp = gen_stamp;
        p.px = gen_pos[0]; p.py = gen_pos[1]; p.pz = gen_pos[2];
        if ($urandom_range(3) == 0) begin
            p.qx = 0; p.qy = 0; p.qz = 0; p.qw = 16'sh7fff;
        end else begin
            p.qx = rand_rot(); p.qy = rand_rot(); p.qz = rand_rot(); p.qw = rand_rot();
        end
        return p;
    endfunction

    function automatic pose_t mk_pose(logic [31:0] s, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z,
                                      logic signed [15:0] a, logic signed [15:0] b,
                                      logic signed [15:0] c, logic signed [15:0] d);
        pose_t p;
        p = '{s, x, y, z, a, b, c, d};
        gen_stamp = s;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_priming();
        send_pose(mk_pose(32'd100, 0, 0, 0, 0, 0, 0, 16'sh7fff));
        send_pose(mk_pose(32'd100, 32'sd65536, 0, 0, 0, 0, 0, 16'sh7fff)); // failed pair
        send_pose(mk_pose(32'd50, 32'sd131072, 0, 0, 0, 0, 0, 16'sh7fff)); // older: replace
        send_pose(mk_pose(32'd20050, 32'sd140000, 32'sd1000, -32'sd5, 0, 0, 0, 16'sh7fff));
        send_pose(mk_pose(32'd40050, 32'sd150000, 32'sd2000, -32'sd9, 0, 0, 0, 16'sh7fff));
        send_pose(mk_pose(32'd40050, 32'sd1, 32'sd2, 32'sd3, 0, 0, 0, 16'sh7fff)); // stale
        send_pose(mk_pose(32'd30000, 32'sd1, 32'sd2, 32'sd3, 0, 0, 0, 16'sh7fff)); // stale
        send_pose(mk_pose(32'd60050, 32'sd160000, 32'sd2500, 0, 16'sh7fff, 0, 0, 0));
    endtask

    task automatic test_extremes();
        send_pose(mk_pose(32'd60051, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));       // d = 1
        send_pose(mk_pose(32'd60052, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
        send_pose(mk_pose(32'd60052 + 32'h7fffffff, 0, 0, 0, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh8000));                           // d = 2^31-1
        send_pose(mk_pose(32'hffffff00, -32'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1,
                          -16'sd1, -16'sd1));
        send_pose(mk_pose(32'h00000100, 32'sd1, 32'sd1, 32'sd1, 0, 0, 0, 0)); // wrap
        send_pose(mk_pose(32'h00000100 + 32'h80000000, 0, 0, 0, 0, 0, 0, 0)); // stale half
        send_pose(mk_pose(32'h00000101, 32'sd3, -32'sd3, 32'sd7, 16'sd1, 16'sd2,
                          16'sd3, 16'sd4));
    endtask

    task automatic test_gravity(logic [GRAVITY_W-1:0] g, int n);
        write_gravity(g);
        for (int i = 0; i < n; i++) send_pose(next_pose());
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_pose(next_pose());
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_pose(next_pose());
    endtask

    initial begin
        gravity_q = GRAVITY_RESET;
        held_count = 0;
        prev_stamp = 0;
        for (int i = 0; i < 3; i++) begin
            prev_pos[i] = 0;
            prev_vel[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_priming();
        test_extremes();
        test_gravity(31'd0, 100);
        test_gravity(31'h7fffffff, 100);
        test_gravity(GRAVITY_RESET, 50);
        idle_on = 1'b0;                // stretch with no idling at all
        test_random(400);
        idle_on = 1'b1;
        test_backpressure();
        test_gravity(31'($urandom), 100);
        test_random(800);

        drain_core();
        $display("sent %0d pose requests, checked %0d acceleration results, %0d gravity writes",
                 requests_sent, results_seen, cfg_writes);
        $display("covered priming, stale drops, stamp wrap, saturation and output hold-off");
        if (errors == 0 && accel_pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", errors, accel_pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/ptba_pkg.sv
hw/rtl/pose_to_body_acceleration_core.sv
hw/rtl/ptba_chk.sv
tb/tb_top.sv
